// ===== rtl/sgc_pkg.sv =====
// Shared constants, register codes and pipeline payload types of the SDF glyph coverage block.
`default_nettype none

package sgc_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int ALPHA_W    = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int BAND_W     = 9;
	localparam int SQ_W       = 18;
	localparam int COEF_W     = 11;
	localparam int CUBE_W     = 27;
	localparam int REM_W      = 36;
	localparam int DIV_STAGES = 9;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	localparam logic [SAMPLE_W-1:0] EDGE_RESET   = 8'd128;
	localparam logic [SAMPLE_W-1:0] SMOOTH_RESET = 8'd26;
	localparam logic [SAMPLE_W-1:0] SPAN_RESET   = 8'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EDGE_LEVEL      = 2'd0,
		REG_SMOOTHING_WIDTH = 2'd1,
		REG_OUTLINE_SPAN    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] edge_level;
		logic [SAMPLE_W-1:0] smoothing_width;
		logic [SAMPLE_W-1:0] outline_span;
	} cfg_t;

	// hard: zero smoothing, lt_*: sample below the band centre, no_ring: zero span.
	typedef struct packed {
		logic hard;
		logic lt_in;
		logic lt_out;
		logic no_ring;
	} flags_t;

	typedef struct packed {
		logic [BAND_W-1:0] n_in;
		logic [BAND_W-1:0] n_out;
		logic [BAND_W-1:0] band;
		flags_t            flags;
	} s1_t;

	typedef struct packed {
		logic [SQ_W-1:0]   nn_in;
		logic [SQ_W-1:0]   nn_out;
		logic [COEF_W-1:0] cf_in;
		logic [COEF_W-1:0] cf_out;
		logic [SQ_W-1:0]   band_sq;
		logic [BAND_W-1:0] band;
		flags_t            flags;
	} s2_t;

	typedef struct packed {
		logic [CUBE_W-1:0] num_in;
		logic [CUBE_W-1:0] num_out;
		logic [CUBE_W-1:0] den;
		flags_t            flags;
	} s3_t;

	typedef struct packed {
		logic [REM_W-1:0]   rem_in;
		logic [REM_W-1:0]   rem_out;
		logic [ALPHA_W-1:0] q_in;
		logic [ALPHA_W-1:0] q_out;
		logic [REM_W-1:0]   dsh;
		flags_t             flags;
	} div_t;

endpackage

`default_nettype wire

// ===== rtl/sgc_cfg_if.sv =====
// Configuration write channel.
`default_nettype none

interface sgc_cfg_if;
	import sgc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SAMPLE_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sgc_sample_if.sv =====
// Distance sample stream channel.
`default_nettype none

interface sgc_sample_if;
	import sgc_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] distance_sample;

	modport source (output valid, distance_sample, input ready);
	modport sink (input valid, distance_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/sgc_coverage_if.sv =====
// Coverage result stream channel.
`default_nettype none

interface sgc_coverage_if;
	import sgc_pkg::*;

	logic               valid;
	logic               ready;
	logic [ALPHA_W-1:0] fill_alpha;
	logic [ALPHA_W-1:0] outline_alpha;

	modport source (output valid, fill_alpha, outline_alpha, input ready);
	modport sink (input valid, fill_alpha, outline_alpha, output ready);
endinterface

`default_nettype wire

// ===== rtl/sgc_cfg_regs.sv =====
// Configuration register file.
`default_nettype none

module sgc_cfg_regs
	import sgc_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	sgc_cfg_if.sink    cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.edge_level      <= EDGE_RESET;
			regs_q.smoothing_width <= SMOOTH_RESET;
			regs_q.outline_span    <= SPAN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_EDGE_LEVEL:      regs_q.edge_level      <= cfg.data;
				REG_SMOOTHING_WIDTH: regs_q.smoothing_width <= cfg.data;
				REG_OUTLINE_SPAN:    regs_q.outline_span    <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sgc_front.sv =====
// Front stages: band position, squares, cubic numerator and denominator, rounded dividend.
`default_nettype none

module sgc_front
	import sgc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  cfg_t        regs,
	sgc_sample_if.sink  sample,
	output logic        dn_valid,
	input  wire         dn_ready,
	output div_t        dn_data
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	s1_t  d_s1, d1_nxt;
	s2_t  d_s2, d2_nxt;
	s3_t  d_s3, d3_nxt;
	div_t d_s4, d4_nxt;

	logic signed [10:0] t_in, t_out;
	logic [BAND_W-1:0]  band;

	assign rdy4         = !vld_s4 || dn_ready;
	assign rdy3         = !vld_s3 || rdy4;
	assign rdy2         = !vld_s2 || rdy3;
	assign rdy1         = !vld_s1 || rdy2;
	assign sample.ready = rdy1;
	assign dn_valid     = vld_s4;
	assign dn_data      = d_s4;

	// Stage 1: sample position inside each band, clamped to 0..band.
	always_comb begin
		band = {regs.smoothing_width, 1'b0};
		t_in = $signed({3'b0, sample.distance_sample}) - $signed({3'b0, regs.edge_level})
			+ $signed({3'b0, regs.smoothing_width});
		t_out = t_in - $signed({3'b0, regs.outline_span});
		if (t_in < 0)
			d1_nxt.n_in = '0;
		else if (t_in > $signed({2'b0, band}))
			d1_nxt.n_in = band;
		else
			d1_nxt.n_in = t_in[BAND_W-1:0];
		if (t_out < 0)
			d1_nxt.n_out = '0;
		else if (t_out > $signed({2'b0, band}))
			d1_nxt.n_out = band;
		else
			d1_nxt.n_out = t_out[BAND_W-1:0];
		d1_nxt.band          = band;
		d1_nxt.flags.hard    = (regs.smoothing_width == '0);
		d1_nxt.flags.lt_in   = (sample.distance_sample < regs.edge_level);
		d1_nxt.flags.lt_out  = ({1'b0, sample.distance_sample}
			< ({1'b0, regs.edge_level} + {1'b0, regs.outline_span}));
		d1_nxt.flags.no_ring = (regs.outline_span == '0);
	end

	// Stage 2: n squared, the (3D - 2n) factor and D squared.
	always_comb begin
		d2_nxt.nn_in   = SQ_W'(d_s1.n_in) * SQ_W'(d_s1.n_in);
		d2_nxt.nn_out  = SQ_W'(d_s1.n_out) * SQ_W'(d_s1.n_out);
		d2_nxt.cf_in   = COEF_W'(3) * COEF_W'(d_s1.band) - {1'b0, d_s1.n_in, 1'b0};
		d2_nxt.cf_out  = COEF_W'(3) * COEF_W'(d_s1.band) - {1'b0, d_s1.n_out, 1'b0};
		d2_nxt.band_sq = SQ_W'(d_s1.band) * SQ_W'(d_s1.band);
		d2_nxt.band    = d_s1.band;
		d2_nxt.flags   = d_s1.flags;
	end

	// Stage 3: the numerator never exceeds D cubed, so both fit the same width.
	always_comb begin
		d3_nxt.num_in  = CUBE_W'(d_s2.nn_in * d_s2.cf_in);
		d3_nxt.num_out = CUBE_W'(d_s2.nn_out * d_s2.cf_out);
		d3_nxt.den     = CUBE_W'(d_s2.band_sq * d_s2.band);
		d3_nxt.flags   = d_s2.flags;
	end

	// Stage 4: scale by 256 and add half the denominator for round-half-up.
	always_comb begin
		d4_nxt.rem_in  = {1'b0, d_s3.num_in, 8'b0} + {10'b0, d_s3.den[CUBE_W-1:1]};
		d4_nxt.rem_out = {1'b0, d_s3.num_out, 8'b0} + {10'b0, d_s3.den[CUBE_W-1:1]};
		d4_nxt.q_in    = '0;
		d4_nxt.q_out   = '0;
		d4_nxt.dsh     = {1'b0, d_s3.den, 8'b0};
		d4_nxt.flags   = d_s3.flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1)
				vld_s1 <= sample.valid;
			if (rdy2)
				vld_s2 <= vld_s1;
			if (rdy3)
				vld_s3 <= vld_s2;
			if (rdy4)
				vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && sample.valid)
			d_s1 <= d1_nxt;
		if (rdy2 && vld_s1)
			d_s2 <= d2_nxt;
		if (rdy3 && vld_s2)
			d_s3 <= d3_nxt;
		if (rdy4 && vld_s3)
			d_s4 <= d4_nxt;
	end

endmodule

`default_nettype wire

// ===== rtl/sgc_div_stage.sv =====
// One restoring-division stage: resolves one quotient bit for both smoothstep lanes.
`default_nettype none

module sgc_div_stage
	import sgc_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   up_valid,
	output logic  up_ready,
	input  div_t  up_data,
	output logic  dn_valid,
	input  wire   dn_ready,
	output div_t  dn_data
);

	logic vld_s1;
	div_t d_s1, d_nxt;
	logic ge_in, ge_out;

	assign up_ready = !vld_s1 || dn_ready;
	assign dn_valid = vld_s1;
	assign dn_data  = d_s1;

	always_comb begin
		ge_in         = (up_data.rem_in >= up_data.dsh);
		ge_out        = (up_data.rem_out >= up_data.dsh);
		d_nxt.rem_in  = ge_in ? up_data.rem_in - up_data.dsh : up_data.rem_in;
		d_nxt.rem_out = ge_out ? up_data.rem_out - up_data.dsh : up_data.rem_out;
		d_nxt.q_in    = {up_data.q_in[ALPHA_W-2:0], ge_in};
		d_nxt.q_out   = {up_data.q_out[ALPHA_W-2:0], ge_out};
		d_nxt.dsh     = up_data.dsh >> 1;
		d_nxt.flags   = up_data.flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (up_ready)
			vld_s1 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid)
			d_s1 <= d_nxt;
	end

	// With a nonzero divisor the remainder must end below the divisor tried in this stage.
	a_rem_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(up_valid && up_ready && !up_data.flags.hard)
		|=> (dn_data.rem_in < $past(up_data.dsh)))
		else $error("inner lane remainder not reduced below divisor");

	a_rem_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(up_valid && up_ready && !up_data.flags.hard)
		|=> (dn_data.rem_out < $past(up_data.dsh)))
		else $error("outer lane remainder not reduced below divisor");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dn_valid && !dn_ready) |=> (dn_valid && $stable(dn_data)))
		else $error("stalled division stage changed its contents");

endmodule

`default_nettype wire

// ===== rtl/sgc_back.sv =====
// Final stage: selects hard or smooth steps, forms fill and outline alphas, output register.
`default_nettype none

module sgc_back
	import sgc_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	input  wire            up_valid,
	output logic           up_ready,
	input  div_t           up_data,
	sgc_coverage_if.source coverage
);

	logic               valid_q;
	logic [ALPHA_W-1:0] fill_q, ring_q;
	logic [ALPHA_W-1:0] inner, outer_step, outer, fill_nxt, ring_nxt;
	logic [2*ALPHA_W-1:0] prod;

	assign up_ready               = !valid_q || coverage.ready;
	assign coverage.valid         = valid_q;
	assign coverage.fill_alpha    = fill_q;
	assign coverage.outline_alpha = ring_q;

	always_comb begin
		if (up_data.flags.hard) begin
			inner      = up_data.flags.lt_in ? '0 : ALPHA_ONE;
			outer_step = up_data.flags.lt_out ? '0 : ALPHA_ONE;
		end else begin
			inner      = up_data.q_in;
			outer_step = up_data.q_out;
		end
		outer    = ALPHA_ONE - outer_step;
		fill_nxt = ALPHA_ONE - inner;
		prod     = (2*ALPHA_W)'(inner) * (2*ALPHA_W)'(outer);
		ring_nxt = up_data.flags.no_ring ? '0 : prod[16:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (up_ready)
			valid_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			fill_q <= fill_nxt;
			ring_q <= ring_nxt;
		end
	end

	a_no_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(up_valid && up_ready && up_data.flags.no_ring) |=> (ring_q == '0))
		else $error("outline present with zero span");

	a_hard_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(up_valid && up_ready && up_data.flags.hard && up_data.flags.lt_in)
		|=> (fill_q == ALPHA_ONE))
		else $error("hard edge inside sample lost full fill");

	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (fill_q <= ALPHA_ONE && ring_q <= ALPHA_ONE))
		else $error("alpha beyond full coverage");

endmodule

`default_nettype wire

// ===== rtl/sdf_glyph_coverage.sv =====
// Top level of the SDF glyph coverage pipeline.
//
//   channel   dir  handshake     payload
//   cfg       in   valid/ready   index[1:0], data[7:0]
//   sample    in   valid/ready   distance_sample[7:0]
//   coverage  out  valid/ready   fill_alpha[8:0], outline_alpha[8:0]
//
// One sample is taken every cycle unless back pressure stalls it; a result passes through
// four arithmetic stages, nine restoring-division stages (one quotient bit each, both
// smoothsteps side by side) and the output register. The division chain sets the depth.
// Reset empties the pipeline and loads the register defaults. A stalled stage holds its
// item and an empty stage keeps filling, so bubbles close up under back pressure.
`default_nettype none

module sdf_glyph_coverage
	import sgc_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	sgc_cfg_if.sink        cfg,
	sgc_sample_if.sink     sample,
	sgc_coverage_if.source coverage
);

	cfg_t regs;
	logic div_vld [DIV_STAGES+1];
	logic div_rdy [DIV_STAGES+1];
	div_t div_dat [DIV_STAGES+1];

	sgc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sgc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.sample   (sample),
		.dn_valid (div_vld[0]),
		.dn_ready (div_rdy[0]),
		.dn_data  (div_dat[0])
	);

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		sgc_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (div_vld[i]),
			.up_ready (div_rdy[i]),
			.up_data  (div_dat[i]),
			.dn_valid (div_vld[i+1]),
			.dn_ready (div_rdy[i+1]),
			.dn_data  (div_dat[i+1])
		);
	end

	sgc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (div_vld[DIV_STAGES]),
		.up_ready (div_rdy[DIV_STAGES]),
		.up_data  (div_dat[DIV_STAGES]),
		.coverage (coverage)
	);

endmodule

`default_nettype wire
